### rtl/icpr_pkg.sv
// Shared types and constants of the ICMP probe reply classifier.
package icpr_pkg;

  localparam int MAX_PACKET_BYTES_DEF = 2048;

  localparam int RX_BYTE_W   = 8;
  localparam int PKT_LEN_W   = 12;
  localparam int CLASS_W     = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int FIELD16_W   = 16;
  localparam int HDR_LEN_W   = 6;

  localparam int ICMP_HDR_BYTES   = 8;
  localparam int IP_MIN_HDR_BYTES = 20;

  localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
  localparam logic [7:0] TYPE_ECHO          = 8'd8;
  localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
  localparam logic [7:0] CODE_IN_TRANSIT    = 8'd0;
  localparam logic [7:0] CODE_ECHO          = 8'd0;

  typedef enum logic [CLASS_W-1:0] {
    CLS_IGNORED       = 2'd0,
    CLS_TIME_EXCEEDED = 2'd1,
    CLS_ECHO_REPLY    = 2'd2
  } icpr_class_e;

  typedef enum logic {
    CFG_EXPECTED_ID  = 1'b0,
    CFG_EXPECTED_SEQ = 1'b1
  } icpr_cfg_e;

  typedef struct packed {
    logic [HDR_LEN_W-1:0] outer_len;
    logic [HDR_LEN_W-1:0] inner_len;
    logic                 time_exceeded;
    logic                 echo_reply;
    logic                 inner_echo;
    logic [FIELD16_W-1:0] outer_ident;
    logic [FIELD16_W-1:0] outer_sequence;
    logic [FIELD16_W-1:0] inner_ident;
    logic [FIELD16_W-1:0] inner_sequence;
  } icpr_hdr_t;

endpackage

### rtl/icpr_if.sv
// Stream interfaces for packet bytes in and classification results out.
interface icpr_byte_if;
  import icpr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [RX_BYTE_W-1:0] rx_byte;
  logic                 last_byte;
  modport source (output valid, output rx_byte, output last_byte, input ready);
  modport sink (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface icpr_result_if;
  import icpr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CLASS_W-1:0]   reply_class;
  logic [PKT_LEN_W-1:0] packet_length;
  modport source (output valid, output reply_class, output packet_length, input ready);
  modport sink (input valid, input reply_class, input packet_length, output ready);
endinterface

### rtl/icmp_probe_reply_classifier.sv
// Top level of the ICMP probe reply classifier.
//
//   channel   dir  handshake     payload
//   in_i      in   valid/ready   rx_byte[7:0], last_byte
//   out_o     out  valid/ready   reply_class[1:0], packet_length[11:0]
//   cfg       in   cfg_we_i      cfg_idx_i (0 expected_id, 1 expected_seq), cfg_data_i[15:0]
//
// One byte is taken per cycle unless the queue is full; a record passes the queue, then the result
// register. The front end captures fields in the cycle a byte is accepted; a two-entry record queue
// feeds the classifier, whose result register pops the queue when empty or when out_o takes a result.
// Reset clears byte count, captured fields, expected id and sequence, and the queue.
// in_i stalls only while the record queue is full.
module icmp_probe_reply_classifier #(
  parameter int MaxPacketBytes = icpr_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  icpr_pkg::icpr_cfg_e             cfg_idx_i,
  input  logic [icpr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  icpr_byte_if.sink                       in_i,
  icpr_result_if.source                   out_o
);
  import icpr_pkg::*;

  localparam int CntW = $clog2(MaxPacketBytes + 1);
  localparam int RecW = CntW + $bits(icpr_hdr_t);

  logic            push, full, head_valid, pop;
  logic [CntW-1:0] push_len, head_len;
  icpr_hdr_t       push_hdr, head_hdr;
  logic [RecW-1:0] head_rec;

  icpr_front #(
    .MaxPacketBytes(MaxPacketBytes),
    .CntW          (CntW)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .len_o  (push_len),
    .hdr_o  (push_hdr)
  );

  icpr_fifo #(
    .DataW(RecW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({push_len, push_hdr}),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (head_valid),
    .data_o  (head_rec)
  );

  assign head_len = head_rec[RecW-1 -: CntW];
  assign head_hdr = head_rec[$bits(icpr_hdr_t)-1:0];

  icpr_back #(
    .MaxPacketBytes(MaxPacketBytes),
    .CntW          (CntW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .valid_i    (head_valid),
    .len_i      (head_len),
    .hdr_i      (head_hdr),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

### rtl/icpr_front.sv
// Byte front end: counts bytes, captures header fields, emits one record per packet.
module icpr_front #(
  parameter int MaxPacketBytes = icpr_pkg::MAX_PACKET_BYTES_DEF,
  parameter int CntW           = $clog2(MaxPacketBytes + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  icpr_byte_if.sink            in_i,
  input  logic                 full_i,
  output logic                 push_o,
  output logic [CntW-1:0]      len_o,
  output icpr_pkg::icpr_hdr_t  hdr_o
);
  import icpr_pkg::*;

  localparam int CmpW = CntW + 2;

  logic [CntW-1:0]      count_q, count_d;
  logic [HDR_LEN_W-1:0] olen_q, olen_d, ilen_q, ilen_d, olen_eff, ilen_eff, nib;
  logic [7:0]           otype_q, otype_d, ocode_q, ocode_d;
  logic [7:0]           itype_q, itype_d, icode_q, icode_d;
  logic [15:0]          oid_q, oid_d, oseq_q, oseq_d, iid_q, iid_d, iseq_q, iseq_d;
  logic [CmpW-1:0]      pos, h, q;
  logic [7:0]           b;
  logic                 accept, room;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.rx_byte;
  assign nib        = {b[3:0], 2'b00};
  assign pos        = CmpW'(count_q);
  assign room       = count_q != CntW'(MaxPacketBytes);
  assign olen_eff   = (count_q == '0) ? nib : olen_q;
  assign h          = CmpW'(olen_eff);
  assign ilen_eff   = (pos == h + CmpW'(ICMP_HDR_BYTES)) ? nib : ilen_q;
  assign q          = h + CmpW'(ICMP_HDR_BYTES) + CmpW'(ilen_eff);

  always_comb begin
    count_d = count_q;
    olen_d  = olen_q;
    ilen_d  = ilen_q;
    otype_d = otype_q;
    ocode_d = ocode_q;
    itype_d = itype_q;
    icode_d = icode_q;
    oid_d   = oid_q;
    oseq_d  = oseq_q;
    iid_d   = iid_q;
    iseq_d  = iseq_q;
    push_o  = 1'b0;
    if (accept && room) begin
      count_d = count_q + CntW'(1);
      olen_d  = olen_eff;
      ilen_d  = ilen_eff;
      if (pos == h) otype_d = b;
      if (pos == h + CmpW'(1)) ocode_d = b;
      if (pos == h + CmpW'(4)) oid_d[15:8] = b;
      if (pos == h + CmpW'(5)) oid_d[7:0] = b;
      if (pos == h + CmpW'(6)) oseq_d[15:8] = b;
      if (pos == h + CmpW'(7)) oseq_d[7:0] = b;
      if (pos == q) itype_d = b;
      if (pos == q + CmpW'(1)) icode_d = b;
      if (pos == q + CmpW'(4)) iid_d[15:8] = b;
      if (pos == q + CmpW'(5)) iid_d[7:0] = b;
      if (pos == q + CmpW'(6)) iseq_d[15:8] = b;
      if (pos == q + CmpW'(7)) iseq_d[7:0] = b;
    end
    len_o                = count_d;
    hdr_o.outer_len      = olen_d;
    hdr_o.inner_len      = ilen_d;
    hdr_o.time_exceeded  = (otype_d == TYPE_TIME_EXCEEDED) && (ocode_d == CODE_IN_TRANSIT);
    hdr_o.echo_reply     = otype_d == TYPE_ECHO_REPLY;
    hdr_o.inner_echo     = (itype_d == TYPE_ECHO) && (icode_d == CODE_ECHO);
    hdr_o.outer_ident    = oid_d;
    hdr_o.outer_sequence = oseq_d;
    hdr_o.inner_ident    = iid_d;
    hdr_o.inner_sequence = iseq_d;
    if (accept && in_i.last_byte) begin
      push_o  = 1'b1;
      count_d = '0;
      olen_d  = '0;
      ilen_d  = '0;
      otype_d = '0;
      ocode_d = '0;
      itype_d = '0;
      icode_d = '0;
      oid_d   = '0;
      oseq_d  = '0;
      iid_d   = '0;
      iseq_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      olen_q  <= '0;
      ilen_q  <= '0;
      otype_q <= '0;
      ocode_q <= '0;
      itype_q <= '0;
      icode_q <= '0;
      oid_q   <= '0;
      oseq_q  <= '0;
      iid_q   <= '0;
      iseq_q  <= '0;
    end else begin
      count_q <= count_d;
      olen_q  <= olen_d;
      ilen_q  <= ilen_d;
      otype_q <= otype_d;
      ocode_q <= ocode_d;
      itype_q <= itype_d;
      icode_q <= icode_d;
      oid_q   <= oid_d;
      oseq_q  <= oseq_d;
      iid_q   <= iid_d;
      iseq_q  <= iseq_d;
    end
  end

endmodule

### rtl/icpr_fifo.sv
// Two-entry record queue between the front end and the classifier.
module icpr_fifo #(
  parameter int DataW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output logic [DataW-1:0] data_o
);
  localparam int Depth  = 2;
  localparam int PtrW   = $clog2(Depth);
  localparam int FillW  = $clog2(Depth + 1);

  logic [DataW-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0] fill_q;
  logic             do_push, do_pop;

  assign full_o  = fill_q == FillW'(Depth);
  assign valid_o = fill_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (do_push && !do_pop) fill_q <= fill_q + FillW'(1);
      else if (do_pop && !do_push) fill_q <= fill_q - FillW'(1);
    end
  end

endmodule

### rtl/icpr_back.sv
// Classifier back end: length rules, match against expected id and sequence, result register.
module icpr_back #(
  parameter int MaxPacketBytes = icpr_pkg::MAX_PACKET_BYTES_DEF,
  parameter int CntW           = $clog2(MaxPacketBytes + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  icpr_pkg::icpr_cfg_e               cfg_idx_i,
  input  logic [icpr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              valid_i,
  input  logic [CntW-1:0]                   len_i,
  input  icpr_pkg::icpr_hdr_t               hdr_i,
  output logic                              pop_o,
  icpr_result_if.source                     out_o
);
  import icpr_pkg::*;

  localparam int CmpW = CntW + 2;

  logic [FIELD16_W-1:0] exp_id_q, exp_seq_q;
  logic                 out_valid_q;
  icpr_class_e          class_q, class_d;
  logic [PKT_LEN_W-1:0] len_q;
  logic [CmpW-1:0]      n, h, h2;
  logic                 too_short, te_short, inner_ok, outer_ok;

  assign n  = CmpW'(len_i);
  assign h  = CmpW'(hdr_i.outer_len);
  assign h2 = CmpW'(hdr_i.inner_len);

  assign too_short = n < h + CmpW'(ICMP_HDR_BYTES);
  assign te_short  = (n < h + CmpW'(ICMP_HDR_BYTES + IP_MIN_HDR_BYTES)) ||
                     (n < h + h2 + CmpW'(2 * ICMP_HDR_BYTES));
  assign inner_ok  = hdr_i.inner_echo && (hdr_i.inner_ident == exp_id_q) &&
                     (hdr_i.inner_sequence == exp_seq_q);
  assign outer_ok  = (hdr_i.outer_ident == exp_id_q) && (hdr_i.outer_sequence == exp_seq_q);

  always_comb begin
    class_d = CLS_IGNORED;
    priority if (too_short) begin
      class_d = CLS_IGNORED;
    end else if (hdr_i.time_exceeded) begin
      if (!te_short && inner_ok) class_d = CLS_TIME_EXCEEDED;
    end else if (hdr_i.echo_reply && outer_ok) begin
      class_d = CLS_ECHO_REPLY;
    end else begin
      class_d = CLS_IGNORED;
    end
  end

  assign pop_o             = valid_i && (!out_valid_q || out_o.ready);
  assign out_o.valid       = out_valid_q;
  assign out_o.reply_class = class_q;
  assign out_o.packet_length = len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_id_q  <= '0;
      exp_seq_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_EXPECTED_ID:  exp_id_q  <= cfg_data_i;
        CFG_EXPECTED_SEQ: exp_seq_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      class_q <= class_d;
      len_q   <= PKT_LEN_W'(len_i);
    end
  end

endmodule
